@@ design/tun_pkg.sv @@
// ----------------------------------------------------------------------------
// tun_pkg
// shared constants for the triangle unit normal block
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 30;
  localparam int OUT_BITS       = 32;

endpackage

`default_nettype wire

@@ design/tun_if.sv @@
// ----------------------------------------------------------------------------
// tun_if
// valid/ready channels for vertex triples and unit normals
// ----------------------------------------------------------------------------
`default_nettype none

interface tun_in_if #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;
  logic signed [COORD_BITS-1:0] third_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    output ready
  );
endinterface

interface tun_out_if;
  logic valid;
  logic ready;
  logic signed [tun_pkg::OUT_BITS-1:0] normal_x;
  logic signed [tun_pkg::OUT_BITS-1:0] normal_y;
  logic signed [tun_pkg::OUT_BITS-1:0] normal_z;
  logic degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

`default_nettype wire

@@ design/tun_cross.sv @@
// ----------------------------------------------------------------------------
// tun_cross
// edge vectors and exact cross product, split into sign and magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module tun_cross #(
  parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic [2:0]                   en,
  input  wire logic signed [COORD_BITS-1:0] a [3],
  input  wire logic signed [COORD_BITS-1:0] b [3],
  input  wire logic signed [COORD_BITS-1:0] c [3],
  output logic [2*(COORD_BITS+1)-1:0]       mag [3],
  output logic                              neg [3]
);
  import tun_pkg::*;

  localparam int UW = COORD_BITS + 1;
  localparam int PW = 2 * UW;
  localparam int MW = 2 * UW;

  logic signed [UW-1:0] u [3];
  logic signed [UW-1:0] v [3];
  logic signed [PW-1:0] pl [3];
  logic signed [PW-1:0] pr [3];
  logic signed [PW:0]   diff [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= UW'(b[i]) - UW'(a[i]);
        v[i] <= UW'(c[i]) - UW'(a[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pl[0] <= u[1] * v[2];
      pr[0] <= u[2] * v[1];
      pl[1] <= u[2] * v[0];
      pr[1] <= u[0] * v[2];
      pl[2] <= u[0] * v[1];
      pr[2] <= u[1] * v[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (PW+1)'(pl[i]) - (PW+1)'(pr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= diff[i][PW] ? MW'(-diff[i]) : MW'(diff[i]);
        neg[i] <= diff[i][PW];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/tun_square.sv @@
// ----------------------------------------------------------------------------
// tun_square
// squares of the cross product components, squared length, scaled residues
// ----------------------------------------------------------------------------
`default_nettype none

module tun_square #(
  parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic [2:0]                     en,
  input  wire logic [2*(COORD_BITS+1)-1:0]    mag [3],
  input  wire logic                           neg_in [3],
  output logic [8*(COORD_BITS+1)+2+2*NORMAL_FRAC_BITS+3-1:0] res [3],
  output logic [8*(COORD_BITS+1)+2+2*NORMAL_FRAC_BITS+3-1:0] sum,
  output logic                                neg [3],
  output logic                                degen
);
  import tun_pkg::*;

  localparam int UW  = COORD_BITS + 1;
  localparam int SQW = 4 * UW;
  localparam int SW  = SQW + 2;
  localparam int DW  = SW + 2 * NORMAL_FRAC_BITS + 3;

  logic [2*UW-1:0] hh [3];
  logic [2*UW-1:0] hl [3];
  logic [2*UW-1:0] ll [3];
  logic [SQW-1:0]  sq [3];
  logic            neg_d [3];
  logic            neg_e [3];
  logic [SW-1:0]   sum_w;

  // halves of each magnitude, three partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        hh[i]    <= mag[i][2*UW-1:UW] * mag[i][2*UW-1:UW];
        hl[i]    <= mag[i][2*UW-1:UW] * mag[i][UW-1:0];
        ll[i]    <= mag[i][UW-1:0] * mag[i][UW-1:0];
        neg_d[i] <= neg_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]    <= (SQW'(hh[i]) << (2*UW)) + (SQW'(hl[i]) << (UW+1)) + SQW'(ll[i]);
        neg_e[i] <= neg_d[i];
      end
    end
  end

  assign sum_w = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= DW'(sq[i]) << (2*NORMAL_FRAC_BITS);
        neg[i] <= neg_e[i];
      end
      sum   <= DW'(sum_w);
      degen <= (sum_w == '0);
    end
  end

endmodule

`default_nettype wire

@@ design/tun_root.sv @@
// ----------------------------------------------------------------------------
// tun_root
// one quotient bit per stage: largest q with q*q*sum <= n*n*2^(2f)
// ----------------------------------------------------------------------------
`default_nettype none

module tun_root #(
  parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic [NORMAL_FRAC_BITS:0]   en,
  input  wire logic [8*(COORD_BITS+1)+2+2*NORMAL_FRAC_BITS+3-1:0] res_in [3],
  input  wire logic [8*(COORD_BITS+1)+2+2*NORMAL_FRAC_BITS+3-1:0] sum_in,
  input  wire logic                        neg_in [3],
  input  wire logic                        degen_in,
  output logic [NORMAL_FRAC_BITS:0]        q [3],
  output logic                             neg [3],
  output logic                             degen
);
  import tun_pkg::*;

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int DW = 8 * (COORD_BITS + 1) + 2 + 2 * F + 3;
  localparam int NS = F + 1;

  // index 0 is the stage input, index NS the last stage
  logic [DW-1:0] rr [NS+1][3];
  logic [DW-1:0] pp [NS+1][3];
  logic [F:0]    qq [NS+1][3];
  logic [DW-1:0] ss [NS+1];
  logic          ng [NS+1][3];
  logic          dg [NS+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[0][i] = res_in[i];
      pp[0][i] = '0;
      qq[0][i] = '0;
      ng[0][i] = neg_in[i];
    end
    ss[0] = sum_in;
    dg[0] = degen_in;
  end

  for (genvar j = 0; j < NS; j++) begin : g_bit
    localparam int B = F - j;
    logic [DW-1:0] sh;
    logic [DW-1:0] delta [3];
    logic          take [3];

    always_comb begin
      sh = ss[j] << B;
      for (int i = 0; i < 3; i++) begin
        delta[i] = ((pp[j][i] << 1) + sh) << B;
        take[i]  = (delta[i] <= rr[j][i]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        for (int i = 0; i < 3; i++) begin
          rr[j+1][i] <= take[i] ? rr[j][i] - delta[i] : rr[j][i];
          pp[j+1][i] <= take[i] ? pp[j][i] + sh : pp[j][i];
          qq[j+1][i] <= qq[j][i] | ((F+1)'(take[i]) << B);
          ng[j+1][i] <= ng[j][i];
        end
        ss[j+1] <= ss[j];
        dg[j+1] <= dg[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i]   = qq[NS][i];
      neg[i] = ng[NS][i];
    end
    degen = dg[NS];
  end

endmodule

`default_nettype wire

@@ design/triangle_unit_normal.sv @@
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit face normal of a triangle, Q8.16 vertices in, Q2.30 normal out
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  vtx      in   first_*, second_*, third_* (x, y, z)
//  nrm      out  normal_x, normal_y, normal_z, degenerate
//
// one triangle per cycle while the output is not stalled; the pipeline depth follows
// NORMAL_FRAC_BITS, set by the bit-per-stage normalising root search
// rst clears only the stage valid bits
// a stalled output holds its stage; bubbles ahead of a stall are filled
`default_nettype none

module triangle_unit_normal #(
  parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  tun_in_if.sink    vtx,
  tun_out_if.source nrm
);
  import tun_pkg::*;

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int UW  = COORD_BITS + 1;
  localparam int DW  = 8 * UW + 2 + 2 * F + 3;
  localparam int NST = F + 8;
  localparam int RB  = 6;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  logic signed [COORD_BITS-1:0] a [3];
  logic signed [COORD_BITS-1:0] b [3];
  logic signed [COORD_BITS-1:0] c [3];
  logic [2*UW-1:0] mag [3];
  logic            neg_c [3];
  logic [DW-1:0]   res [3];
  logic [DW-1:0]   sum;
  logic            neg_s [3];
  logic            degen_s;
  logic [F:0]      q [3];
  logic            neg_r [3];
  logic            degen_r;
  logic signed [OUT_BITS-1:0] nv [3];

  // stage k moves when it is empty or the stage after it moves; the last one when empty or nrm.ready
  always_comb begin
    en[NST-1] = !v[NST-1] || nrm.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= vtx.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign vtx.ready = en[0];

  assign a[0] = vtx.first_x;
  assign a[1] = vtx.first_y;
  assign a[2] = vtx.first_z;
  assign b[0] = vtx.second_x;
  assign b[1] = vtx.second_y;
  assign b[2] = vtx.second_z;
  assign c[0] = vtx.third_x;
  assign c[1] = vtx.third_y;
  assign c[2] = vtx.third_z;

  tun_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk (clk),
    .en  (en[2:0]),
    .a   (a),
    .b   (b),
    .c   (c),
    .mag (mag),
    .neg (neg_c)
  );

  tun_square #(
    .COORD_BITS      (COORD_BITS),
    .NORMAL_FRAC_BITS(F)
  ) u_square (
    .clk    (clk),
    .en     (en[5:3]),
    .mag    (mag),
    .neg_in (neg_c),
    .res    (res),
    .sum    (sum),
    .neg    (neg_s),
    .degen  (degen_s)
  );

  tun_root #(
    .COORD_BITS      (COORD_BITS),
    .NORMAL_FRAC_BITS(F)
  ) u_root (
    .clk      (clk),
    .en       (en[RB+F:RB]),
    .res_in   (res),
    .sum_in   (sum),
    .neg_in   (neg_s),
    .degen_in (degen_s),
    .q        (q),
    .neg      (neg_r),
    .degen    (degen_r)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (degen_r) begin
        nv[i] = '0;
      end else if (neg_r[i]) begin
        nv[i] = -OUT_BITS'(q[i]);
      end else begin
        nv[i] = OUT_BITS'(q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      nrm.normal_x   <= nv[0];
      nrm.normal_y   <= nv[1];
      nrm.normal_z   <= nv[2];
      nrm.degenerate <= degen_r;
    end
  end

  assign nrm.valid = v[NST-1];

  // a degenerate transaction carries a zero normal
  assert property (@(posedge clk) disable iff (rst)
    (nrm.valid && nrm.degenerate) |->
      (nrm.normal_x == 0 && nrm.normal_y == 0 && nrm.normal_z == 0))
    else $error("degenerate result with nonzero normal");

  // components never exceed one in magnitude
  assert property (@(posedge clk) disable iff (rst)
    nrm.valid |->
      ($signed(nrm.normal_x) <= $signed(OUT_BITS'(1) << F) &&
       $signed(nrm.normal_x) >= -$signed(OUT_BITS'(1) << F) &&
       $signed(nrm.normal_y) <= $signed(OUT_BITS'(1) << F) &&
       $signed(nrm.normal_y) >= -$signed(OUT_BITS'(1) << F) &&
       $signed(nrm.normal_z) <= $signed(OUT_BITS'(1) << F) &&
       $signed(nrm.normal_z) >= -$signed(OUT_BITS'(1) << F)))
    else $error("normal component out of range");

  // input is refused only when every stage is occupied
  assert property (@(posedge clk) disable iff (rst)
    !vtx.ready |-> (&v))
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

@@ dv/triangle_unit_normal_tb.sv @@
// ----------------------------------------------------------------------------
// triangle_unit_normal_tb
// streams vertex triples through the block and compares each unit normal
// with an exact integer prediction, under phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_unit_normal_tb;

  localparam int CB = tun_pkg::COORD_BITS_DEF;
  localparam int FB = tun_pkg::FRAC_BITS_DEF;
  localparam int OB = tun_pkg::OUT_BITS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } triangle_t;

  typedef struct packed {
    logic [OB-1:0] nx, ny, nz;
    logic          degenerate;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tun_in_if #(.COORD_BITS(CB)) vtx ();
  tun_out_if nrm ();

  triangle_unit_normal dut (
    .clk(clk),
    .rst(rst),
    .vtx(vtx.sink),
    .nrm(nrm.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  triangle_t pending_triangles[$];
  normal_t   expected_normals[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_sender = 1'b0;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;

  // integer square root of a value below 2^64
  function automatic logic [63:0] root_floor(logic [255:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({192'd0, t} * {192'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic normal_t unit_normal_of(triangle_t t);
    logic signed [63:0] u[3], v[3], a[3];
    logic signed [127:0] c[3];
    logic [255:0] len_sq, num, quo;
    logic [127:0] mag;
    logic [63:0] q;
    logic [OB-1:0] comp[3];
    normal_t r;
    a[0] = 64'(signed'(t.ax)); a[1] = 64'(signed'(t.ay)); a[2] = 64'(signed'(t.az));
    u[0] = 64'(signed'(t.bx)) - a[0];
    u[1] = 64'(signed'(t.by)) - a[1];
    u[2] = 64'(signed'(t.bz)) - a[2];
    v[0] = 64'(signed'(t.cx)) - a[0];
    v[1] = 64'(signed'(t.cy)) - a[1];
    v[2] = 64'(signed'(t.cz)) - a[2];
    c[0] = 128'(u[1]) * 128'(v[2]) - 128'(u[2]) * 128'(v[1]);
    c[1] = 128'(u[2]) * 128'(v[0]) - 128'(u[0]) * 128'(v[2]);
    c[2] = 128'(u[0]) * 128'(v[1]) - 128'(u[1]) * 128'(v[0]);
    len_sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag = c[i] < 0 ? 128'(-c[i]) : 128'(c[i]);
      len_sq += {128'd0, mag} * {128'd0, mag};
    end
    r = '0;
    if (len_sq == '0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      mag = c[i] < 0 ? 128'(-c[i]) : 128'(c[i]);
      num = ({128'd0, mag} * {128'd0, mag}) << (2 * FB);
      quo = num / len_sq;
      q = root_floor(quo);
      if (c[i] < 0) q = -q;
      comp[i] = q[OB-1:0];
    end
    r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [OB-1:0] got, logic [OB-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      vtx.valid <= 1'b0;
      {vtx.first_x, vtx.first_y, vtx.first_z, vtx.second_x, vtx.second_y,
       vtx.second_z, vtx.third_x, vtx.third_y, vtx.third_z} <= '0;
    end else if (!vtx.valid || vtx.ready) begin
      if (pending_triangles.size() != 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        triangle_t t;
        t = pending_triangles.pop_front();
        vtx.valid <= 1'b1;
        {vtx.first_x, vtx.first_y, vtx.first_z, vtx.second_x, vtx.second_y,
         vtx.second_z, vtx.third_x, vtx.third_y, vtx.third_z} <= t;
        expected_normals.push_back(unit_normal_of(t));
      end else begin
        vtx.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      nrm.ready <= 1'b0;
    end else begin
      if (nrm.valid && nrm.ready) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("unexpected transaction", nrm.normal_x, '0);
        end else begin
          normal_t e;
          e = expected_normals.pop_front();
          if (nrm.normal_x !== e.nx) report_mismatch("normal_x", nrm.normal_x, e.nx);
          if (nrm.normal_y !== e.ny) report_mismatch("normal_y", nrm.normal_y, e.ny);
          if (nrm.normal_z !== e.nz) report_mismatch("normal_z", nrm.normal_z, e.nz);
          if (nrm.degenerate !== e.degenerate)
            report_mismatch("degenerate", OB'(nrm.degenerate), OB'(e.degenerate));
        end
      end
      nrm.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("triangle_unit_normal_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: return CB'($signed($urandom_range(65536 * 8)) - 65536 * 4);
    endcase
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int mode;
    mode = $urandom_range(3);
    t.ax = rand_coord(mode); t.ay = rand_coord(mode); t.az = rand_coord(mode);
    t.bx = rand_coord(mode); t.by = rand_coord(mode); t.bz = rand_coord(mode);
    t.cx = rand_coord(mode); t.cy = rand_coord(mode); t.cz = rand_coord(mode);
    case ($urandom_range(15))
      0: begin t.bx = t.ax; t.by = t.ay; t.bz = t.az; end   // repeated vertex
      1: begin t.cx = t.ax; t.cy = t.ay; t.cz = t.az; end
      2: begin t.az = t.ax; t.bz = t.ax; t.cz = t.ax; end  // plane z = const
      3: begin                                             // collinear points
        t.cx = t.bx + (t.bx - t.ax); t.cy = t.by + (t.by - t.ay);
        t.cz = t.bz + (t.bz - t.az);
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic wait_drained();
    while (pending_triangles.size() != 0 || expected_normals.size() != 0)
      @(posedge clk);
  endtask

  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] ONE  = CB'(65536);

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: degenerate, axis-aligned normals, extremes
    pending_triangles.push_back('0);
    pending_triangles.push_back('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    pending_triangles.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0});
    pending_triangles.push_back('{0, 0, 0, 0, ONE, 0, ONE, 0, 0});
    pending_triangles.push_back('{0, 0, 0, 0, ONE, 0, 0, 0, ONE});
    pending_triangles.push_back('{0, 0, 0, 0, 0, ONE, ONE, 0, 0});
    pending_triangles.push_back('{0, 0, 0, 0, 0, ONE, 0, ONE, 0});
    pending_triangles.push_back('{0, 0, 0, ONE, 0, 0, 0, 0, ONE});
    pending_triangles.push_back('{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN});
    pending_triangles.push_back('{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX});
    pending_triangles.push_back('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX});
    pending_triangles.push_back('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN});
    pending_triangles.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    pending_triangles.push_back('{0, 0, 0, 1, 1, 1, 2, 2, 2});
    pending_triangles.push_back('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN});
    pending_triangles.push_back('{0, 0, 0, CMAX, 0, 0, 0, CMIN, 1});
    pending_triangles.push_back('{'1, '1, '1, 0, 0, 0, 1, '1, 0});
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        3: begin send_idle_pct = 24; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 250; i++) pending_triangles.push_back(random_triangle());
      if (phase == 2) begin
        // pause the sender midway until the pipeline has fully drained
        while (pending_triangles.size() > 125) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_normals.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_normals.size() == 0)
      $display("triangle_unit_normal_tb OK");
    else
      $display("triangle_unit_normal_tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
design/tun_pkg.sv
design/tun_if.sv
design/tun_cross.sv
design/tun_square.sv
design/tun_root.sv
design/triangle_unit_normal.sv
dv/triangle_unit_normal_tb.sv
